FILE: src/cidp_pkg.sv
// shared types and constants for the caller-id sdmf parser
package cidp_pkg;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } cidp_state_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_TYPE  = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;
    localparam logic [1:0] STATUS_RANGE = 2'd3;

    localparam logic [7:0] DIGIT_BASE   = 8'd48;
    localparam logic [7:0] TYPE_RESET   = 8'd4;
    localparam int         TIME_START   = 2;
    localparam int         NUM_START    = 10;
    localparam int         TIME_CHARS   = 8;
    localparam int         TRAILER      = 3;
    localparam int         OUT_W        = 64;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic emit;
        logic clear;
    } cidp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic last_result;
    } cidp_sts_t;

endpackage

FILE: src/cidp_ctrl.sv
// control state machine: collect frame bytes, then emit the result burst
module cidp_ctrl
    import cidp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  cidp_sts_t   sts,
    output cidp_cmd_t   cmd
);

    cidp_state_t state_reg;
    cidp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.last_result)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        cmd.take  = 1'b0;
        cmd.emit  = 1'b0;
        cmd.clear = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_EMIT:
            begin
                cmd.emit  = sts.out_free;
                // frame state goes back to zero with the final word
                cmd.clear = sts.out_free && sts.last_result;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/cidp_datapath.sv
// frame registers, number store, result selection and output register
module cidp_datapath
    import cidp_pkg::*;
#(
    parameter int NUMBER_CHARS = 16,
    parameter int MAX_FRAME    = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic [7:0]        data_byte,
    input  cidp_cmd_t         cmd,
    output cidp_sts_t         sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast
);

    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam int IDX_W = (NUMBER_CHARS > 1) ? $clog2(NUMBER_CHARS) : 1;
    localparam int CNT_W = $clog2(NUMBER_CHARS + 1);

    logic [7:0]       type_reg;
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [7:0]       len_reg,    len_next;
    logic             type_ok_reg, type_ok_next;
    logic [7:0]       month_reg,  month_next;
    logic [7:0]       day_reg,    day_next;
    logic [7:0]       hour_reg,   hour_next;
    logic [7:0]       minute_reg, minute_next;
    logic [7:0]       check_reg,  check_next;
    logic [CNT_W-1:0] idx_reg,    idx_next;
    logic             valid_reg,  valid_next;
    logic [OUT_W-1:0] data_reg,   data_next;
    logic             last_reg,   last_next;

    logic [7:0]       store [NUMBER_CHARS];
    logic             store_we;
    logic [IDX_W-1:0] store_addr;
    logic [7:0]       store_q;

    logic [8:0]       pos9;
    logic [8:0]       off9;
    logic [7:0]       digit;
    logic [7:0]       digit_val;
    logic [1:0]       digit_sel;
    logic [9:0]       count10;
    logic             err_short;
    logic             err_range;
    logic [1:0]       status;
    logic             good;
    logic [8:0]       nlen9;
    logic [8:0]       result_cnt;
    logic             is_last;
    logic             char_valid;
    logic [7:0]       number_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= TYPE_RESET;
        end
        else if (cfg_we)
        begin
            type_reg <= cfg_wdata;
        end
    end

    // byte intake
    always_comb
    begin
        pos9      = 9'(pos_reg);
        off9      = pos9 - 9'(NUM_START);
        digit     = data_byte - DIGIT_BASE;
        digit_sel = 2'((pos9 - 9'(TIME_START)) >> 1);

        pos_next     = pos_reg;
        len_next     = len_reg;
        type_ok_next = type_ok_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        check_next   = check_reg;
        store_we     = 1'b0;
        store_addr   = off9[IDX_W-1:0];

        // tens digit opens the value, units digit adds to it
        if (!pos9[0])
        begin
            digit_val = (digit << 3) + (digit << 1);
        end
        else
        begin
            digit_val = 8'd0;
            case (digit_sel)
                2'd0:    digit_val = month_reg + digit;
                2'd1:    digit_val = day_reg + digit;
                2'd2:    digit_val = hour_reg + digit;
                default: digit_val = minute_reg + digit;
            endcase
        end

        if (cmd.clear)
        begin
            pos_next     = '0;
            len_next     = '0;
            type_ok_next = 1'b0;
            month_next   = '0;
            day_next     = '0;
            hour_next    = '0;
            minute_next  = '0;
            check_next   = '0;
        end
        else if (cmd.take && (pos_reg < POS_W'(MAX_FRAME)))
        begin
            pos_next = pos_reg + 1'b1;
            if (pos9 == 9'd0)
            begin
                type_ok_next = (data_byte == type_reg);
            end
            else if (pos9 == 9'd1)
            begin
                len_next = data_byte;
            end
            else
            begin
                if (pos9 < 9'(NUM_START))
                begin
                    case (digit_sel)
                        2'd0:    month_next  = digit_val;
                        2'd1:    day_next    = digit_val;
                        2'd2:    hour_next   = digit_val;
                        default: minute_next = digit_val;
                    endcase
                end
                else if (off9 < 9'(NUMBER_CHARS))
                begin
                    store_we = 1'b1;
                end
                if (pos9 == (9'(len_reg) + 9'd2))
                begin
                    check_next = data_byte;
                end
            end
        end
    end

    // read data follows the index of the next cycle
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store[store_addr] <= data_byte;
        end
        store_q <= store[idx_next[IDX_W-1:0]];
    end

    // frame verdict, wrong type first, then short, then length range
    always_comb
    begin
        count10   = 10'(pos_reg);
        err_short = count10 < (10'(len_reg) + 10'(TRAILER));
        err_range = (len_reg < 8'(TIME_CHARS))
                    || (9'(len_reg) > 9'(TIME_CHARS + NUMBER_CHARS));
        if (!type_ok_reg)
        begin
            status = STATUS_TYPE;
        end
        else if (err_short)
        begin
            status = STATUS_SHORT;
        end
        else if (err_range)
        begin
            status = STATUS_RANGE;
        end
        else
        begin
            status = STATUS_OK;
        end
        good       = (status == STATUS_OK);
        nlen9      = 9'(len_reg) - 9'(TIME_CHARS);
        char_valid = good && (nlen9 != 9'd0);
        result_cnt = char_valid ? nlen9 : 9'd1;
        is_last    = (9'(idx_reg) + 9'd1) == result_cnt;
        number_char = char_valid ? store_q : 8'd0;
    end

    assign sts.last_result = is_last;
    assign sts.out_free    = !valid_reg || m_tready;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            valid_next = 1'b1;
            last_next  = is_last;
            data_next  = {char_valid,
                          number_char,
                          good ? nlen9[4:0] : 5'd0,
                          len_reg,
                          good ? check_reg : 8'd0,
                          good ? minute_reg : 8'd0,
                          good ? hour_reg : 8'd0,
                          good ? day_reg : 8'd0,
                          good ? month_reg : 8'd0,
                          status};
            idx_next   = cmd.clear ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= '0;
            type_ok_reg <= 1'b0;
            month_reg   <= '0;
            day_reg     <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            check_reg   <= '0;
            idx_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            type_ok_reg <= type_ok_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            check_reg   <= check_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: src/caller_id_sdmf_parser_top.sv
// caller-id sdmf parser: one frame byte per cycle, result burst at frame end
// after the last byte is taken, the emit state registers the first result word
// throughput: 1 byte per cycle while collecting; the burst gives 1 word per cycle unless
// stalled (number length words, or one if none or on error), no byte taken meanwhile
// reset: asynchronous active-low, frame state and output valid cleared,
// message type register back to 4; the number store is not cleared
module caller_id_sdmf_parser_top
    import cidp_pkg::*;
#(
    parameter int NUMBER_CHARS = 16,
    parameter int MAX_FRAME    = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,     // message_type
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,       // data_byte
    input  logic              s_tlast,       // frame_end
    output logic              m_tvalid,
    input  logic              m_tready,
    // status[1:0] month[9:2] day[17:10] hour[25:18] minute[33:26]
    // check_byte[41:34] message_length[49:42] number_length[54:50]
    // number_char[62:55] char_valid[63]
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast        // last
);

    cidp_cmd_t cmd;
    cidp_sts_t sts;

    cidp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cidp_datapath #(
        .NUMBER_CHARS (NUMBER_CHARS),
        .MAX_FRAME    (MAX_FRAME)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: src/cidp_checker.sv
// port-level checks for the caller-id sdmf parser
module cidp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // no byte is taken while a burst is still running
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready during result burst");

    // an error frame gives a single word
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != 2'd0) |-> m_tlast && (m_tdata[54:50] == 5'd0))
        else $error("error word not alone or carries a number length");

    // no character without its valid flag, and a word without it is the last
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[63] |-> (m_tdata[62:55] == 8'd0) && m_tlast)
        else $error("character without valid flag");

endmodule

bind caller_id_sdmf_parser_top cidp_checker u_cidp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
